// ===== sv/lshs_pkg.sv =====
// Shared constants and types for the luma sub-pixel horizontal shifter.
// Used by the interpolator, top level and checker; no dependencies.
`timescale 1ns / 1ps

package lshs_pkg;

    localparam int MAX_SHIFT_PIXELS_DEF = 5;
    // Fraction of a pixel per shift step is 1 / 2**FRAC_BITS
    localparam int FRAC_BITS            = 4;
    localparam int FRACTION_STEPS       = 1 << FRAC_BITS;

    localparam int LUMA_W     = 8;
    localparam int CHROMA_W   = 8;
    localparam int SHIFT_W    = 8;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 8;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ENABLE = 1'b0,
        CFG_SHIFT  = 1'b1
    } cfg_reg_t;

    typedef struct packed {
        logic                      enable;
        logic signed [SHIFT_W-1:0] shift;
    } shift_cfg_t;

endpackage

// ===== sv/lshs_cell.sv =====
// One stage of the pixel window: holds a pixel and passes it on when the row shifts.
// Depends on nothing.
`timescale 1ns / 1ps

module lshs_cell
#(
    parameter int W = 8
)
(
    input  logic         clk,
    input  logic         shift_en,
    input  logic [W-1:0] d,
    output logic [W-1:0] q
);

    logic [W-1:0] data_reg;

    always_ff @(posedge clk)
    begin
        if (shift_en)
        begin
            data_reg <= d;
        end
    end

    assign q = data_reg;

endmodule

// ===== sv/lshs_interp.sv =====
// Tap selection and two-tap linear blend of the luma window.
// Depends on lshs_pkg.
`timescale 1ns / 1ps

module lshs_interp
    import lshs_pkg::*;
#(
    parameter int MAX_SHIFT_PIXELS = MAX_SHIFT_PIXELS_DEF
)
(
    input  logic [LUMA_W-1:0]                           win [2*MAX_SHIFT_PIXELS+1],
    input  logic [$clog2(2*MAX_SHIFT_PIXELS+2)-1:0]     count,
    input  shift_cfg_t                                  cfg,
    output logic [LUMA_W-1:0]                           luma
);

    localparam int WIN_LEN   = 2 * MAX_SHIFT_PIXELS + 1;
    localparam int WIN_IDX_W = $clog2(WIN_LEN);
    localparam int CNT_W     = $clog2(WIN_LEN + 1);
    localparam int MAG_W     = SHIFT_W + 1;
    localparam int MAG_MAX   = MAX_SHIFT_PIXELS * FRACTION_STEPS;
    localparam int COEF_W    = FRAC_BITS + 1;
    localparam int PROD_W    = LUMA_W + COEF_W;
    localparam int SUM_W     = PROD_W + 1;
    localparam logic [WIN_IDX_W-1:0] CENTRE = WIN_IDX_W'(MAX_SHIFT_PIXELS);

    logic                 neg;
    logic [MAG_W-1:0]     s_ext;
    logic [MAG_W-1:0]     mag;
    logic [WIN_IDX_W-1:0] d1;
    logic [WIN_IDX_W-1:0] d2;
    logic [FRAC_BITS-1:0] c2;
    logic [COEF_W-1:0]    c1;
    logic [WIN_IDX_W-1:0] j1;
    logic [WIN_IDX_W-1:0] j2;
    logic [WIN_IDX_W-1:0] last_idx;
    logic [WIN_IDX_W-1:0] idx1;
    logic [WIN_IDX_W-1:0] idx2;
    logic [PROD_W-1:0]    prod1;
    logic [PROD_W-1:0]    prod2;
    logic [SUM_W-1:0]     sum;
    logic [SUM_W-1:0]     blend;

    always_comb
    begin
        neg   = cfg.shift[SHIFT_W-1];
        s_ext = {cfg.shift[SHIFT_W-1], cfg.shift};
        mag   = neg ? (MAG_W'(0) - s_ext) : s_ext;
        if (!cfg.enable)
        begin
            mag = '0;
        end
        if (int'(mag) > MAG_MAX)
        begin
            mag = MAG_W'(MAG_MAX);
        end

        d1 = WIN_IDX_W'(mag >> FRAC_BITS);
        c2 = mag[FRAC_BITS-1:0];
        d2 = d1 + WIN_IDX_W'(c2 != '0);
        c1 = COEF_W'(FRACTION_STEPS) - {1'b0, c2};

        j1 = neg ? (CENTRE - d1) : (CENTRE + d1);
        j2 = neg ? (CENTRE - d2) : (CENTRE + d2);

        // older taps stop at the first pixel of the line
        last_idx = WIN_IDX_W'(count - CNT_W'(1));
        idx1     = j1;
        idx2     = j2;
        if (count != '0 && CNT_W'(j1) >= count)
        begin
            idx1 = last_idx;
        end
        if (count != '0 && CNT_W'(j2) >= count)
        begin
            idx2 = last_idx;
        end

        prod1 = PROD_W'(win[idx1]) * PROD_W'(c1);
        prod2 = PROD_W'(win[idx2]) * PROD_W'(c2);
        sum   = SUM_W'(prod1) + SUM_W'(prod2);
        blend = sum >> FRAC_BITS;
        if (blend > SUM_W'({LUMA_W{1'b1}}))
        begin
            luma = {LUMA_W{1'b1}};
        end
        else
        begin
            luma = blend[LUMA_W-1:0];
        end
    end

endmodule

// ===== sv/luma_subpixel_horizontal_shift.sv =====
// Luma sub-pixel horizontal shifter, top level.
// Depends on lshs_pkg, lshs_cell and lshs_interp.
`timescale 1ns / 1ps

// Takes one YUY2 pixel per clock and returns one pixel per clock, the luma moved
// horizontally by shift_reg/16 of a pixel by blending two neighbouring taps;
// chroma is passed through. Each result leaves MAX_SHIFT_PIXELS pixels after
// its input, and every request produces exactly one result. The pixels
// sit in a row of 2*MAX_SHIFT_PIXELS+1 cells that shifts one place per pixel pushed,
// which sets the rate at one pixel per cycle while the output is taken and no
// line is draining. After a request with line_end the row keeps shifting in
// copies of the last pixel to drain the line: input is held off, whatever the
// line length, until every result of the line has been captured. Configuration
// writes are taken on every cycle and should only be made while the block is idle.

module luma_subpixel_horizontal_shift
    import lshs_pkg::*;
#(
    parameter int MAX_SHIFT_PIXELS = MAX_SHIFT_PIXELS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,

    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [LUMA_W-1:0]     luma_in,
    input  logic [CHROMA_W-1:0]   chroma_in,
    input  logic                  line_end,

    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [LUMA_W-1:0]     luma_out,
    output logic [CHROMA_W-1:0]   chroma_out,
    output logic                  line_end_out,

    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int WIN_LEN = 2 * MAX_SHIFT_PIXELS + 1;
    localparam int CHR_LEN = MAX_SHIFT_PIXELS + 1;
    localparam int CNT_W   = $clog2(WIN_LEN + 1);
    localparam int PEND_W  = $clog2(MAX_SHIFT_PIXELS + 2);
    localparam int OLD_W   = $clog2(MAX_SHIFT_PIXELS + 1);
    localparam int PIX_W   = LUMA_W + CHROMA_W;

    // configuration
    logic                      enable_reg;
    logic signed [SHIFT_W-1:0] shift_reg;
    shift_cfg_t                shift_cfg;

    // window control
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;
    logic [PEND_W-1:0] pend_reg;
    logic [PEND_W-1:0] pend_next;
    logic [OLD_W-1:0]  old_reg;
    logic [OLD_W-1:0]  old_next;
    logic              flush_reg;
    logic              flush_next;

    // output register
    logic                out_valid_reg;
    logic [LUMA_W-1:0]   luma_out_reg;
    logic [CHROMA_W-1:0] chroma_out_reg;
    logic                last_reg;

    logic              owe;
    logic              out_free;
    logic              cap;
    logic              advance;
    logic              in_acc;
    logic              dup_push;
    logic              push;
    logic              flush_done;
    logic [PEND_W-1:0] pend_left;
    logic [OLD_W-1:0]  old_dec;

    logic [LUMA_W-1:0]   feed_luma;
    logic [CHROMA_W-1:0] feed_chroma;
    logic [LUMA_W-1:0]   luma_q   [WIN_LEN];
    logic [CHROMA_W-1:0] chroma_q [CHR_LEN];
    logic [LUMA_W-1:0]   blend_luma;

    //------------------------------------------------------------------
    // Configuration registers
    //------------------------------------------------------------------
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg <= 1'b0;
            shift_reg  <= '0;
        end
        else if (cfg_valid)
        begin
            case (cfg_reg_t'(cfg_index))
                CFG_ENABLE: enable_reg <= cfg_data[0];
                CFG_SHIFT:  shift_reg  <= SHIFT_W'(cfg_data);
                default:    ;
            endcase
        end
    end

    assign shift_cfg.enable = enable_reg;
    assign shift_cfg.shift  = shift_reg;

    //------------------------------------------------------------------
    // Window control
    // old_reg is the window position of the oldest pixel still owed a
    // result; that result is due once it reaches the centre cell.
    //------------------------------------------------------------------
    always_comb
    begin
        owe        = (pend_reg != '0) && (old_reg == OLD_W'(MAX_SHIFT_PIXELS));
        out_free   = !out_valid_reg || out_ready;
        cap        = owe && out_free;
        advance    = !owe || out_free;
        in_ready   = !flush_reg && advance;
        in_acc     = in_valid && in_ready;
        pend_left  = pend_reg - PEND_W'(cap);
        dup_push   = flush_reg && advance && (pend_left != '0);
        push       = in_acc || dup_push;
        flush_done = flush_reg && (pend_left == '0);
        old_dec    = old_reg - OLD_W'(cap);

        pend_next = pend_left + PEND_W'(in_acc);

        old_next = old_dec;
        if (push)
        begin
            old_next = (pend_left == '0) ? '0 : (old_dec + OLD_W'(1));
        end

        count_next = count_reg;
        if (flush_done)
        begin
            count_next = '0;
        end
        else if (push && count_reg < CNT_W'(WIN_LEN))
        begin
            count_next = count_reg + CNT_W'(1);
        end

        flush_next = flush_reg;
        if (in_acc && line_end)
        begin
            flush_next = 1'b1;
        end
        else if (flush_done)
        begin
            flush_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            pend_reg  <= '0;
            old_reg   <= '0;
            flush_reg <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            pend_reg  <= pend_next;
            old_reg   <= old_next;
            flush_reg <= flush_next;
        end
    end

    //------------------------------------------------------------------
    // Cell row; while draining, the newest pixel is fed back in
    //------------------------------------------------------------------
    assign feed_luma   = flush_reg ? luma_q[0]   : luma_in;
    assign feed_chroma = flush_reg ? chroma_q[0] : chroma_in;

    for (genvar i = 0; i < WIN_LEN; i++)
    begin : g_cell
        if (i < CHR_LEN)
        begin : g_full
            logic [PIX_W-1:0] d_w;
            logic [PIX_W-1:0] q_w;

            if (i == 0)
            begin : g_head
                assign d_w = {feed_luma, feed_chroma};
            end
            else
            begin : g_body
                assign d_w = {luma_q[i-1], chroma_q[i-1]};
            end

            lshs_cell #(.W(PIX_W)) u_cell
            (
                .clk      (clk),
                .shift_en (push),
                .d        (d_w),
                .q        (q_w)
            );

            assign luma_q[i]   = q_w[PIX_W-1:CHROMA_W];
            assign chroma_q[i] = q_w[CHROMA_W-1:0];
        end
        else
        begin : g_luma
            lshs_cell #(.W(LUMA_W)) u_cell
            (
                .clk      (clk),
                .shift_en (push),
                .d        (luma_q[i-1]),
                .q        (luma_q[i])
            );
        end
    end

    lshs_interp #(.MAX_SHIFT_PIXELS(MAX_SHIFT_PIXELS)) u_interp
    (
        .win   (luma_q),
        .count (count_reg),
        .cfg   (shift_cfg),
        .luma  (blend_luma)
    );

    //------------------------------------------------------------------
    // Output register
    //------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cap)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cap)
        begin
            luma_out_reg   <= blend_luma;
            chroma_out_reg <= chroma_q[MAX_SHIFT_PIXELS];
            last_reg       <= flush_reg && (pend_reg == PEND_W'(1));
        end
    end

    assign out_valid    = out_valid_reg;
    assign luma_out     = luma_out_reg;
    assign chroma_out   = chroma_out_reg;
    assign line_end_out = last_reg;

endmodule

// ===== sv/lshs_checker.sv =====
// Port-level checks for the luma sub-pixel horizontal shifter, bound to the top level.
// Depends on lshs_pkg and luma_subpixel_horizontal_shift.
`timescale 1ns / 1ps

module lshs_checker
    import lshs_pkg::*;
#(
    parameter int MAX_SHIFT_PIXELS = MAX_SHIFT_PIXELS_DEF
)
(
    input logic                clk,
    input logic                rst_n,
    input logic                in_valid,
    input logic                in_ready,
    input logic                line_end,
    input logic                out_valid,
    input logic                out_ready,
    input logic [LUMA_W-1:0]   luma_out,
    input logic [CHROMA_W-1:0] chroma_out,
    input logic                line_end_out
);

    localparam int OUT_W = $clog2(MAX_SHIFT_PIXELS + 3) + 1;

    logic             in_acc;
    logic             out_acc;
    logic [OUT_W-1:0] outstanding_reg;
    logic [OUT_W-1:0] outstanding_next;
    logic [1:0]       lines_reg;
    logic [1:0]       lines_next;

    assign in_acc  = in_valid && in_ready;
    assign out_acc = out_valid && out_ready;

    // requests taken but not yet answered, and lines whose last result is owed
    always_comb
    begin
        outstanding_next = outstanding_reg + OUT_W'(in_acc) - OUT_W'(out_acc);
        lines_next       = lines_reg + 2'(in_acc && line_end) - 2'(out_acc && line_end_out);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            outstanding_reg <= '0;
            lines_reg       <= '0;
        end
        else
        begin
            outstanding_reg <= outstanding_next;
            lines_reg       <= lines_next;
        end
    end

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(luma_out)
            && $stable(chroma_out) && $stable(line_end_out))
        else $error("result changed while stalled");

    a_no_orphan: assert property (@(posedge clk) disable iff (!rst_n)
        out_acc |-> outstanding_reg != '0)
        else $error("result without a request");

    a_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        outstanding_reg <= OUT_W'(MAX_SHIFT_PIXELS + 2))
        else $error("too many requests in flight");

    a_line_close: assert property (@(posedge clk) disable iff (!rst_n)
        out_acc && line_end_out |-> lines_reg != '0)
        else $error("line end out without a line end in");

endmodule

bind luma_subpixel_horizontal_shift lshs_checker #(.MAX_SHIFT_PIXELS(MAX_SHIFT_PIXELS))
    u_lshs_checker (.*);
